/* rtl/core/metadata_stream_header_parser_top_defines.svh */
// Assertion macros shared by the checker of the metadata stream header parser.
// Depends on nothing; files that assert take it in by include and provide clk and rst_n.
`ifndef METADATA_STREAM_HEADER_PARSER_TOP_DEFINES_SVH
`define METADATA_STREAM_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication on clk, disabled while rst_n is low.
`define MSHP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, disabled while rst_n is low.
`define MSHP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mshp_pkg.sv */
// Types and constants of the metadata stream header parser.
// Depends on nothing; used by the top level, the checker and the testbench.
package mshp_pkg;

    localparam logic [31:0] SIG_WORD     = 32'h424A_5342;
    localparam logic [31:0] VERSION_WORD = 32'h0001_0001;

    // Byte offsets inside the root header and inside one stream header.
    localparam int unsigned MIN_SECTION     = 16;
    localparam int unsigned SIG_LAST        = 3;
    localparam int unsigned VER_LAST        = 7;
    localparam int unsigned VLEN_LAST       = 15;
    localparam int unsigned ROOT_FIXED      = 20;
    localparam int unsigned MIN_ENTRY_LEFT  = 9;
    localparam int unsigned ENTRY_OFF_LAST  = 3;
    localparam int unsigned ENTRY_SIZE_LAST = 7;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_SIGNATURE   = 3'd1,
        STATUS_VERSION     = 3'd2,
        STATUS_VERSION_LEN = 3'd3,
        STATUS_WALK        = 3'd4
    } status_t;

    typedef enum logic {
        KIND_STREAM  = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       record_kind;
        logic [15:0] entry_index;
        logic [31:0] entry_offset;
        logic [31:0] entry_size;
        logic [31:0] header_size;
        logic [15:0] declared_streams;
        status_t     status;
        logic        last;
    } record_t;

endpackage

/* rtl/core/mshp_byte_if.sv */
// Byte channel carrying the metadata section into the parser.
// Depends on nothing.
interface mshp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_section;

    modport source (output valid, output data_byte, output start_of_section, input ready);
    modport sink (input valid, input data_byte, input start_of_section, output ready);
endinterface

/* rtl/core/mshp_rec_if.sv */
// Record channel carrying stream header and summary records out of the parser.
// Depends on nothing.
interface mshp_rec_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [15:0] entry_index;
    logic [31:0] entry_offset;
    logic [31:0] entry_size;
    logic [31:0] header_size;
    logic [15:0] declared_streams;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, output record_kind, output entry_index,
                    output entry_offset, output entry_size, output header_size,
                    output declared_streams, output status, output last, input ready);
    modport sink (input valid, input record_kind, input entry_index,
                  input entry_offset, input entry_size, input header_size,
                  input declared_streams, input status, input last, output ready);
    modport monitor (input valid, input ready, input record_kind, input entry_index,
                     input entry_offset, input entry_size, input header_size,
                     input declared_streams, input status, input last);
endinterface

/* rtl/core/metadata_stream_header_parser_top.sv */
// Each record is written into the output queue as the byte that caused it is accepted.
// Throughput: one byte per cycle; a byte may give two records, which a four-word
// output queue absorbs, and ready falls only while fewer than two slots are free.
// Reset (rst_n, asynchronous, active low) clears the parse phase, the output queue
// and the section length; bytes are then ignored until a start-of-section mark.
module metadata_stream_header_parser_top
    import mshp_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [31:0]  wr_data,
    mshp_byte_if.sink    section,
    mshp_rec_if.source   records
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_ENTRY,
        PH_NAME,
        PH_PAD,
        PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [31:0]            pos_reg, pos_next;
    logic [31:0]            shift_reg, shift_next;
    logic [31:0]            hend_reg, hend_next;
    logic [15:0]            left_reg, left_next;
    logic [15:0]            found_reg, found_next;
    logic [31:0]            hoff_reg, hoff_next;
    logic [31:0]            hsize_reg, hsize_next;
    logic [LENGTH_BITS-1:0] len_reg;

    record_t                fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;

    logic                   accept;
    logic                   pop;
    logic [1:0]             n_res;
    record_t                rec0, rec1;

    assign section.ready = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign accept        = section.valid && section.ready;
    assign records.valid = (count_reg != '0);
    assign pop           = records.valid && records.ready;

    always_comb
    begin
        phase_t      c_phase;
        logic [31:0] c_pos;
        logic [31:0] c_shift;
        logic [31:0] c_hend;
        logic [15:0] c_left;
        logic [15:0] c_found;
        logic [31:0] c_hoff;
        logic [31:0] c_hsize;
        logic [31:0] sh;
        logic [31:0] rel;
        logic [33:0] len_x;
        logic [33:0] next_x;
        logic [33:0] pad_x;
        logic        want_stream;
        logic        want_sum;
        logic [31:0] sum_hsize;
        status_t     sum_status;
        logic        ne_do;
        logic [31:0] ne_h;
        record_t     stream_rec;
        record_t     sum_rec;

        c_phase = phase_reg;
        c_pos   = pos_reg;
        c_shift = shift_reg;
        c_hend  = hend_reg;
        c_left  = left_reg;
        c_found = found_reg;
        c_hoff  = hoff_reg;
        c_hsize = hsize_reg;
        if (section.start_of_section)
        begin
            c_phase = PH_HEADER;
            c_pos   = '0;
            c_shift = '0;
            c_hend  = '0;
            c_left  = '0;
            c_found = '0;
            c_hoff  = '0;
            c_hsize = '0;
        end

        len_x       = 34'(len_reg);
        next_x      = 34'(c_pos) + 34'd1;
        sh          = {section.data_byte, c_shift[31:8]};
        rel         = c_pos - c_hend;
        pad_x       = 34'({1'b0, sh[31:2]}) + 34'(|sh[1:0]);
        pad_x       = {pad_x[31:0], 2'b00};
        want_stream = 1'b0;
        want_sum    = 1'b0;
        sum_hsize   = '0;
        sum_status  = STATUS_OK;
        ne_do       = 1'b0;
        ne_h        = c_hend;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        hend_next  = hend_reg;
        left_next  = left_reg;
        found_next = found_reg;
        hoff_next  = hoff_reg;
        hsize_next = hsize_reg;

        if (accept)
        begin
            phase_next = c_phase;
            pos_next   = c_pos;
            shift_next = c_shift;
            hend_next  = c_hend;
            left_next  = c_left;
            found_next = c_found;
            hoff_next  = c_hoff;
            hsize_next = c_hsize;

            if (c_phase != PH_IDLE && c_phase != PH_DONE &&
                !(34'(c_pos) >= len_x && c_phase != PH_HEADER))
            begin
                shift_next = sh;
                pos_next   = next_x[31:0];
                case (c_phase)
                    PH_HEADER:
                    begin
                        if (c_pos == '0 && len_x < 34'(MIN_SECTION))
                        begin
                            want_sum   = 1'b1;
                            sum_status = STATUS_SIGNATURE;
                        end
                        else if (c_pos == 32'(SIG_LAST))
                        begin
                            if (sh != SIG_WORD)
                            begin
                                want_sum   = 1'b1;
                                sum_status = STATUS_SIGNATURE;
                            end
                        end
                        else if (c_pos == 32'(VER_LAST))
                        begin
                            if (sh != VERSION_WORD)
                            begin
                                want_sum   = 1'b1;
                                sum_status = STATUS_VERSION;
                            end
                        end
                        else if (c_pos == 32'(VLEN_LAST))
                        begin
                            // The padded length is at most 33 bits, so one
                            // compare also rejects a length that wraps.
                            if (pad_x + 34'(ROOT_FIXED) > len_x)
                            begin
                                want_sum   = 1'b1;
                                sum_status = STATUS_VERSION_LEN;
                            end
                            else
                            begin
                                hend_next = pad_x[31:0] + 32'(ROOT_FIXED);
                            end
                        end
                        else if (c_pos >= 32'(MIN_SECTION) && next_x == 34'(c_hend))
                        begin
                            left_next  = sh[31:16];
                            found_next = '0;
                            ne_do      = 1'b1;
                        end
                    end
                    PH_ENTRY:
                    begin
                        if (rel == 32'(ENTRY_OFF_LAST))
                        begin
                            hoff_next = sh;
                        end
                        else if (rel == 32'(ENTRY_SIZE_LAST))
                        begin
                            hsize_next = sh;
                            if (34'(c_hoff) >= len_x || sh == '0 ||
                                34'(c_hoff) + 34'(sh) > len_x)
                            begin
                                want_sum   = 1'b1;
                                sum_status = STATUS_WALK;
                                sum_hsize  = c_hend;
                            end
                            else
                            begin
                                phase_next = PH_NAME;
                            end
                        end
                    end
                    PH_NAME:
                    begin
                        if (section.data_byte != 8'd0)
                        begin
                            if (next_x >= len_x)
                            begin
                                want_sum   = 1'b1;
                                sum_status = STATUS_WALK;
                                sum_hsize  = c_hend;
                            end
                        end
                        else
                        begin
                            want_stream = 1'b1;
                            found_next  = c_found + 16'd1;
                            left_next   = c_left - 16'd1;
                            if (next_x[1:0] == 2'b00 || next_x >= len_x)
                            begin
                                hend_next = next_x[31:0];
                                ne_h      = next_x[31:0];
                                ne_do     = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAD;
                            end
                        end
                    end
                    PH_PAD:
                    begin
                        if (next_x[1:0] == 2'b00 || next_x >= len_x)
                        begin
                            hend_next = next_x[31:0];
                            ne_h      = next_x[31:0];
                            ne_do     = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // Decide at the committed offset whether another entry follows.
                if (ne_do)
                begin
                    sum_hsize = ne_h;
                    if (left_next == '0)
                    begin
                        want_sum   = 1'b1;
                        sum_status = STATUS_OK;
                    end
                    else if (len_x < 34'(ne_h) + 34'(MIN_ENTRY_LEFT))
                    begin
                        want_sum   = 1'b1;
                        sum_status = STATUS_WALK;
                    end
                    else
                    begin
                        phase_next = PH_ENTRY;
                    end
                end
                if (want_sum)
                begin
                    phase_next = PH_DONE;
                end
            end
        end

        stream_rec.record_kind      = KIND_STREAM;
        stream_rec.entry_index      = c_found;
        stream_rec.entry_offset     = c_hoff;
        stream_rec.entry_size       = c_hsize;
        stream_rec.header_size      = '0;
        stream_rec.declared_streams = c_found + c_left;
        stream_rec.status           = STATUS_OK;
        stream_rec.last             = !want_sum;

        sum_rec.record_kind      = KIND_SUMMARY;
        sum_rec.entry_index      = found_next;
        sum_rec.entry_offset     = '0;
        sum_rec.entry_size       = '0;
        sum_rec.header_size      = sum_hsize;
        sum_rec.declared_streams = found_next + left_next;
        sum_rec.status           = sum_status;
        sum_rec.last             = 1'b1;

        rec0  = want_stream ? stream_rec : sum_rec;
        rec1  = sum_rec;
        n_res = 2'(want_stream) + 2'(want_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            len_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (wr_en)
            begin
                len_reg <= wr_data[LENGTH_BITS-1:0];
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(n_res) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        shift_reg <= shift_next;
        hend_reg  <= hend_next;
        left_reg  <= left_next;
        found_reg <= found_next;
        hoff_reg  <= hoff_next;
        hsize_reg <= hsize_next;
        if (n_res != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= rec0;
        end
        if (n_res == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= rec1;
        end
    end

    assign records.record_kind      = fifo_reg[rd_ptr_reg].record_kind;
    assign records.entry_index      = fifo_reg[rd_ptr_reg].entry_index;
    assign records.entry_offset     = fifo_reg[rd_ptr_reg].entry_offset;
    assign records.entry_size       = fifo_reg[rd_ptr_reg].entry_size;
    assign records.header_size      = fifo_reg[rd_ptr_reg].header_size;
    assign records.declared_streams = fifo_reg[rd_ptr_reg].declared_streams;
    assign records.status           = fifo_reg[rd_ptr_reg].status;
    assign records.last             = fifo_reg[rd_ptr_reg].last;

endmodule

/* rtl/core/mshp_checker.sv */
// Checker on the record port of the metadata stream header parser, bound to the top level.
// Depends on mshp_pkg and the assertion macros header.
`include "metadata_stream_header_parser_top_defines.svh"

module mshp_checker
    import mshp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    rec_valid,
    input logic    rec_ready,
    input record_t rec_data
);

    logic is_sum;
    logic is_stream;
    logic stalled;
    logic stream_ok;
    logic sum_ok;

    assign is_sum    = rec_valid && rec_data.record_kind == KIND_SUMMARY;
    assign is_stream = rec_valid && rec_data.record_kind == KIND_STREAM;
    assign stalled   = rec_valid && !rec_ready;
    assign stream_ok = rec_data.status == STATUS_OK && rec_data.header_size == '0;
    assign sum_ok    = rec_data.entry_offset == '0 && rec_data.entry_size == '0 &&
                       rec_data.status <= STATUS_WALK;

    // A summary always closes the records of its byte.
    `MSHP_ASSERT_IMP(a_summary_last, is_sum, rec_data.last, "summary record without last")

    // Stream header records carry no status and no header size.
    `MSHP_ASSERT_IMP(a_stream_clean, is_stream, stream_ok, "stream record with summary fields")

    // Summaries carry no entry words and only defined status codes.
    `MSHP_ASSERT_IMP(a_summary_clean, is_sum, sum_ok, "malformed summary record")

    // A stalled word stays on the port unchanged.
    `MSHP_ASSERT_NXT(a_stall_hold, stalled, rec_valid && $stable(rec_data), "stalled word changed")

endmodule

bind metadata_stream_header_parser_top mshp_checker u_mshp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (records.valid),
    .rec_ready (records.ready),
    .rec_data  ({records.record_kind, records.entry_index, records.entry_offset,
                 records.entry_size, records.header_size, records.declared_streams,
                 records.status, records.last})
);

/* tb/metadata_stream_header_parser_top_tb.sv */
// Testbench of metadata_stream_header_parser_top: feeds metadata sections word by word,
// predicts every stream header and summary record, and checks each record on arrival.
// Depends on mshp_pkg, mshp_byte_if, mshp_rec_if and the parser top level.
module metadata_stream_header_parser_top_tb
    import mshp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        P_IDLE,
        P_HEADER,
        P_ENTRY,
        P_NAME,
        P_PAD,
        P_DONE
    } walk_phase_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_SIGNATURE,
        FLAW_VERSION,
        FLAW_VERSION_LEN,
        FLAW_ENTRY,
        FLAW_COUNT,
        FLAW_CUT
    } section_flaw_t;

    // Walks the section as the parser should and keeps the records still owed.
    class header_walk_model;
        record_t     due_records[$];
        logic [31:0] section_len;
        walk_phase_t walk;
        logic [31:0] pos_cnt;
        logic [31:0] shift_word;
        logic [31:0] walk_start;
        logic [15:0] streams_left;
        logic [15:0] streams_found;
        logic [31:0] cur_offset;
        logic [31:0] cur_size;
        int unsigned mismatch_count;
        int unsigned records_predicted;
        int unsigned bytes_parsed;

        function new();
            section_len = '0;
            walk = P_IDLE;
            pos_cnt = '0;
            shift_word = '0;
            walk_start = '0;
            streams_left = '0;
            streams_found = '0;
            cur_offset = '0;
            cur_size = '0;
            mismatch_count = 0;
            records_predicted = 0;
            bytes_parsed = 0;
        endfunction

        function void queue_record(kind_t k, logic [15:0] idx, logic [31:0] off,
                                   logic [31:0] sz, logic [31:0] hsz, status_t st);
            record_t r;
            r.record_kind = k;
            r.entry_index = idx;
            r.entry_offset = off;
            r.entry_size = sz;
            r.header_size = hsz;
            r.declared_streams = streams_found + streams_left;
            r.status = st;
            r.last = 1'b0;
            due_records.push_back(r);
            records_predicted++;
        endfunction

        function void close_walk(logic [31:0] hsz, status_t st);
            walk = P_DONE;
            queue_record(KIND_SUMMARY, streams_found, '0, '0, hsz, st);
        endfunction

        // At a committed offset: stop when the count is used up or too little remains.
        function void next_entry();
            logic [32:0] room;
            room = (section_len > walk_start) ? {1'b0, section_len} - {1'b0, walk_start} : '0;
            if (streams_left == 0)
                close_walk(walk_start, STATUS_OK);
            else if (room < MIN_ENTRY_LEFT)
                close_walk(walk_start, STATUS_WALK);
            else
                walk = P_ENTRY;
        endfunction

        function void take_byte(logic [7:0] b, logic sos);
            logic [31:0] p;
            logic [31:0] rel;
            logic [32:0] nxt;
            logic [32:0] padded;
            int unsigned held;
            record_t tail;
            if (sos)
            begin
                walk = P_HEADER;
                pos_cnt = '0;
                shift_word = '0;
                walk_start = '0;
                streams_left = '0;
                streams_found = '0;
                cur_offset = '0;
                cur_size = '0;
            end
            if (walk == P_IDLE || walk == P_DONE)
                return;
            p = pos_cnt;
            if (p >= section_len && walk != P_HEADER)
                return;
            bytes_parsed++;
            held = due_records.size();
            shift_word = {b, shift_word[31:8]};
            pos_cnt = p + 32'd1;
            nxt = {1'b0, p} + 33'd1;
            rel = p - walk_start;

            case (walk)
                P_HEADER:
                begin
                    if (p == 0 && section_len < MIN_SECTION)
                        close_walk('0, STATUS_SIGNATURE);
                    else if (p == SIG_LAST)
                    begin
                        if (shift_word != SIG_WORD)
                            close_walk('0, STATUS_SIGNATURE);
                    end
                    else if (p == VER_LAST)
                    begin
                        if (shift_word != VERSION_WORD)
                            close_walk('0, STATUS_VERSION);
                    end
                    else if (p == VLEN_LAST)
                    begin
                        padded = {1'b0, shift_word};
                        if (padded[1:0] != 2'b00)
                            padded = padded + (33'd4 - padded[1:0]);
                        if (padded[32] || padded + ROOT_FIXED > {1'b0, section_len})
                            close_walk('0, STATUS_VERSION_LEN);
                        else
                            walk_start = padded[31:0] + ROOT_FIXED;
                    end
                    else if (p >= MIN_SECTION && nxt == {1'b0, walk_start})
                    begin
                        streams_left = shift_word[31:16];
                        streams_found = '0;
                        next_entry();
                    end
                end
                P_ENTRY:
                begin
                    if (rel == ENTRY_OFF_LAST)
                        cur_offset = shift_word;
                    else if (rel == ENTRY_SIZE_LAST)
                    begin
                        cur_size = shift_word;
                        if (cur_offset >= section_len || cur_size == 0 ||
                            {1'b0, cur_offset} + {1'b0, cur_size} > {1'b0, section_len})
                            close_walk(walk_start, STATUS_WALK);
                        else
                            walk = P_NAME;
                    end
                end
                P_NAME:
                begin
                    if (b != 8'd0)
                    begin
                        if (nxt >= {1'b0, section_len})
                            close_walk(walk_start, STATUS_WALK);
                    end
                    else
                    begin
                        queue_record(KIND_STREAM, streams_found, cur_offset, cur_size, '0,
                                     STATUS_OK);
                        streams_found = streams_found + 16'd1;
                        streams_left = streams_left - 16'd1;
                        if (nxt[1:0] == 2'b00 || nxt >= {1'b0, section_len})
                        begin
                            walk_start = nxt[31:0];
                            next_entry();
                        end
                        else
                            walk = P_PAD;
                    end
                end
                P_PAD:
                begin
                    if (nxt[1:0] == 2'b00 || nxt >= {1'b0, section_len})
                    begin
                        walk_start = nxt[31:0];
                        next_entry();
                    end
                end
                default:
                    ;
            endcase

            if (due_records.size() > held)
            begin
                tail = due_records.pop_back();
                tail.last = 1'b1;
                due_records.push_back(tail);
            end
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatch_count++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void match_record(record_t got);
            record_t want;
            if (due_records.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: record expected none, got %h", $time, got);
                return;
            end
            want = due_records.pop_front();
            check_field("record_kind", want.record_kind, got.record_kind);
            check_field("entry_index", want.entry_index, got.entry_index);
            check_field("entry_offset", want.entry_offset, got.entry_offset);
            check_field("entry_size", want.entry_size, got.entry_size);
            check_field("header_size", want.header_size, got.header_size);
            check_field("declared_streams", want.declared_streams, got.declared_streams);
            check_field("status", want.status, got.status);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        wr_en;
    logic [31:0] wr_data;
    record_t     seen;

    mshp_byte_if byte_ch();
    mshp_rec_if  rec_ch();

    header_walk_model walker = new();

    // Each planned word is {start_of_section, data_byte}.
    logic [8:0]  byte_plan[$];
    bit          pace_gaps = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned hold_len = 0;

    metadata_stream_header_parser_top #(
        .LENGTH_BITS(32)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_data(wr_data),
        .section(byte_ch),
        .records(rec_ch)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (wr_en)
                walker.section_len = wr_data;
            if (rec_ch.valid && rec_ch.ready)
            begin
                seen = {rec_ch.record_kind, rec_ch.entry_index, rec_ch.entry_offset,
                        rec_ch.entry_size, rec_ch.header_size, rec_ch.declared_streams,
                        rec_ch.status, rec_ch.last};
                walker.match_record(seen);
            end
            if (byte_ch.valid && byte_ch.ready)
                walker.take_byte(byte_ch.data_byte, byte_ch.start_of_section);
        end
    end

    // Record receiver; a requested hold is counted out here while the sender carries on.
    initial
    begin
        rec_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rec_ch.ready <= 1'b0;
                for (int c = 0; c < hold_len; c++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            rec_ch.ready <= !pace_gaps || ($urandom_range(99) >= 27);
        end
    end

    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    function automatic void add_le32(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            byte_plan.push_back({1'b0, w[8*i +: 8]});
    endfunction

    function automatic void add_section(logic [31:0] limit);
        section_flaw_t flaw;
        int unsigned   first;
        int unsigned   count;
        int unsigned   declared;
        int unsigned   bad_at;
        int unsigned   keep;
        logic [31:0]   vlen;
        logic [31:0]   padded;
        logic [31:0]   off;
        logic [31:0]   sz;
        logic [31:0]   word;
        flaw = ($urandom_range(99) < 55) ? FLAW_NONE : section_flaw_t'($urandom_range(6, 1));
        repeat (($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0)
            byte_plan.push_back({1'b0, 8'($urandom)});
        first = byte_plan.size();

        word = SIG_WORD;
        if (flaw == FLAW_SIGNATURE)
            word = word ^ (32'd1 << $urandom_range(31, 0));
        add_le32(word);
        byte_plan[first] = {1'b1, byte_plan[first][7:0]};
        word = VERSION_WORD;
        if (flaw == FLAW_VERSION)
            word = word ^ (32'd1 << $urandom_range(31, 0));
        add_le32(word);
        add_le32($urandom);

        vlen = $urandom_range(12, 0);
        if (flaw == FLAW_VERSION_LEN)
        begin
            case ($urandom_range(2, 0))
                0: vlen = 32'hFFFF_FFFD + $urandom_range(2, 0);
                1: vlen = $urandom;
                default: vlen = (limit >= ROOT_FIXED) ? limit - (ROOT_FIXED - 1) : vlen;
            endcase
            add_le32(vlen);
            repeat ($urandom_range(3, 0))
                byte_plan.push_back({1'b0, 8'($urandom)});
            return;
        end
        add_le32(vlen);
        padded = (vlen + 32'd3) & ~32'd3;
        for (int i = 0; i < padded; i++)
            byte_plan.push_back({1'b0, (i < vlen) ? 8'($urandom_range(255, 1)) : 8'd0});

        count = $urandom_range(4, 0);
        if (flaw == FLAW_ENTRY && count == 0)
            count = 1;
        declared = (flaw == FLAW_COUNT) ? $urandom_range(65535, 0) : count;
        bad_at = $urandom_range(count - 1, 0);
        byte_plan.push_back({1'b0, 8'($urandom)});
        byte_plan.push_back({1'b0, 8'($urandom)});
        byte_plan.push_back({1'b0, declared[7:0]});
        byte_plan.push_back({1'b0, declared[15:8]});

        for (int k = 0; k < count; k++)
        begin
            off = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(limit - 32'd1, 0);
            sz = ($urandom_range(3) == 0) ? limit - off : $urandom_range(limit - off, 1);
            if (flaw == FLAW_ENTRY && k == bad_at)
            begin
                case ($urandom_range(2, 0))
                    0: sz = '0;
                    1: off = limit;
                    default:
                    begin
                        off = limit - 32'd1;
                        sz = $urandom_range(7, 2);
                    end
                endcase
            end
            add_le32(off);
            add_le32(sz);
            repeat ($urandom_range(8, 1))
                byte_plan.push_back({1'b0, 8'($urandom_range(255, 1))});
            byte_plan.push_back({1'b0, 8'd0});
            while (((byte_plan.size() - first) & 3) != 0)
                byte_plan.push_back({1'b0, 8'($urandom)});
        end

        // A cut section is left unfinished; the next start mark abandons it.
        if (flaw == FLAW_CUT)
        begin
            keep = $urandom_range(byte_plan.size() - first - 1, 1);
            while (byte_plan.size() > first + keep)
                void'(byte_plan.pop_back());
        end
    endfunction

    task automatic send_plan();
        foreach (byte_plan[i])
        begin
            if (pace_gaps)
                while ($urandom_range(99) < 27)
                begin
                    byte_ch.valid <= 1'b0;
                    @(posedge clk);
                end
            byte_ch.valid <= 1'b1;
            byte_ch.start_of_section <= byte_plan[i][8];
            byte_ch.data_byte <= byte_plan[i][7:0];
            @(posedge clk);
            while (!byte_ch.ready)
                @(posedge clk);
        end
        byte_ch.valid <= 1'b0;
        byte_plan.delete();
    endtask

    // Words that give no record may still be in flight once the queue is empty.
    // The first edge lets the monitor take the last word before the queue is looked at.
    task automatic drain_records();
        @(posedge clk);
        while (walker.due_records.size() != 0 || rec_ch.valid)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_length(logic [31:0] value);
        wr_en <= 1'b1;
        wr_data <= value;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] span;
        int unsigned phase_no;
        int unsigned sections;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_data = '0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.start_of_section = 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // Stray words before any section, sections shorter than the root header,
        // then a broken signature and a broken version word.
        drain_records();
        write_length(32'd0);
        byte_plan.push_back({1'b0, 8'hFF});
        byte_plan.push_back({1'b1, 8'h00});
        byte_plan.push_back({1'b0, 8'h42});
        send_plan();
        drain_records();
        write_length(32'd15);
        byte_plan.push_back({1'b1, 8'h42});
        send_plan();
        drain_records();
        write_length(32'd16);
        add_le32(SIG_WORD ^ 32'h0100_0000);
        byte_plan[0] = {1'b1, byte_plan[0][7:0]};
        add_le32(SIG_WORD);
        byte_plan[4] = {1'b1, byte_plan[4][7:0]};
        add_le32(VERSION_WORD ^ 32'h0002_0000);
        send_plan();

        phase_no = 0;
        while (walker.bytes_parsed < 750 || walker.records_predicted < 60)
        begin
            case ($urandom_range(19, 0))
                0: span = 32'hFFFF_FFFF;
                1: span = $urandom_range(15, 0);
                2, 3: span = $urandom;
                4, 5, 6, 7, 8: span = $urandom_range(80, 16);
                default: span = $urandom_range(400, 80);
            endcase
            sections = $urandom_range(4, 1);
            if (phase_no == 2)
            begin
                span = 32'd400;
                sections = 4;
            end
            drain_records();
            write_length(span);
            pace_gaps = !(phase_no >= 4 && phase_no < 7);
            repeat (sections)
                add_section(span);
            if (phase_no == 2)
            begin
                hold_len = 150;
                hold_request = 1'b1;
            end
            send_plan();
            phase_no++;
        end
        pace_gaps = 1'b1;

        drain_records();
        if (walker.mismatch_count == 0 && walker.due_records.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/mshp_pkg.sv
rtl/core/mshp_byte_if.sv
rtl/core/mshp_rec_if.sv
rtl/core/metadata_stream_header_parser_top.sv
rtl/core/mshp_checker.sv
tb/metadata_stream_header_parser_top_tb.sv
